// ===== src/shalb_pkg.sv =====
`default_nettype none
package shalb_pkg;

    localparam int COEFF_WIDTH = 20;
    localparam int Q_SHADE     = 43;
    localparam int BASIS_W     = 34;
    localparam int TERM_W      = COEFF_WIDTH + BASIS_W;
    localparam int SUM_W       = TERM_W + 4;
    localparam int DIV_W       = SUM_W + 8;
    localparam int NUM_W       = 8 + Q_SHADE;
    localparam int DIV_STEPS   = 8;
    localparam int FRONT_LAT   = 5;
    localparam int CFG_DATA_W  = 3 * COEFF_WIDTH;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = CFG_IDX_W'(3);

    localparam logic [15:0] THRESH_RESET = 16'd13626;
    localparam logic [CFG_DATA_W-1:0] COEFF_0_RESET = CFG_DATA_W'(32768);

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic               normal_valid;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
    } t_pix_in;

    typedef struct packed {
        logic       visible;
        logic [7:0] albedo_red;
        logic [7:0] albedo_green;
        logic [7:0] albedo_blue;
        logic [7:0] irradiance_red;
        logic [7:0] irradiance_green;
        logic [7:0] irradiance_blue;
    } t_pix_out;

    typedef struct packed {
        logic                    visible;
        logic signed [SUM_W-1:0] shade;
        logic [7:0]              color_red;
        logic [7:0]              color_green;
        logic [7:0]              color_blue;
    } t_front_out;

endpackage
`default_nettype wire

// ===== src/shalb_front.sv =====
`default_nettype none
module shalb_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire shalb_pkg::t_pix_in                i_pix,
    input  wire logic [31:0]                       i_thr_sq,
    input  wire logic [3*shalb_pkg::CFG_DATA_W-1:0] i_coeffs,
    output shalb_pkg::t_front_out                  o_front
);
    import shalb_pkg::*;

    // stage 1: raw products
    logic signed [31:0] r_pxnx, r_pyny, r_pznz, r_pxx, r_pyy, r_pzz;
    logic signed [31:0] r_nxx, r_nyy, r_nzz, r_nxy, r_nyz, r_nzx;
    logic signed [15:0] r_nx1, r_ny1, r_nz1;
    logic               r_nv1;
    logic [7:0]         r_cr1, r_cg1, r_cb1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxnx <= 32'(i_pix.point_x) * 32'(i_pix.nrm_x);
            r_pyny <= 32'(i_pix.point_y) * 32'(i_pix.nrm_y);
            r_pznz <= 32'(i_pix.point_z) * 32'(i_pix.nrm_z);
            r_pxx  <= 32'(i_pix.point_x) * 32'(i_pix.point_x);
            r_pyy  <= 32'(i_pix.point_y) * 32'(i_pix.point_y);
            r_pzz  <= 32'(i_pix.point_z) * 32'(i_pix.point_z);
            r_nxx  <= 32'(i_pix.nrm_x) * 32'(i_pix.nrm_x);
            r_nyy  <= 32'(i_pix.nrm_y) * 32'(i_pix.nrm_y);
            r_nzz  <= 32'(i_pix.nrm_z) * 32'(i_pix.nrm_z);
            r_nxy  <= 32'(i_pix.nrm_x) * 32'(i_pix.nrm_y);
            r_nyz  <= 32'(i_pix.nrm_y) * 32'(i_pix.nrm_z);
            r_nzx  <= 32'(i_pix.nrm_z) * 32'(i_pix.nrm_x);
            r_nx1  <= i_pix.nrm_x;
            r_ny1  <= i_pix.nrm_y;
            r_nz1  <= i_pix.nrm_z;
            r_nv1  <= i_pix.normal_valid;
            r_cr1  <= i_pix.color_red;
            r_cg1  <= i_pix.color_green;
            r_cb1  <= i_pix.color_blue;
        end
    end

    // stage 2: dot products and basis terms
    logic signed [33:0]        n_d, n_p2s;
    logic signed [BASIS_W-1:0] r_b2 [9];
    logic signed [BASIS_W-1:0] n_b [9];
    logic [31:0]               r_d2v, r_p2;
    logic                      r_ok2;
    logic [7:0]                r_cr2, r_cg2, r_cb2;

    always_comb begin
        n_d   = -(34'(r_pxnx) + 34'(r_pyny) + 34'(r_pznz));
        n_p2s = 34'(r_pxx) + 34'(r_pyy) + 34'(r_pzz);
        n_b[0] = BASIS_W'(1) <<< 28;
        n_b[1] = BASIS_W'(r_ny1) <<< 14;
        n_b[2] = BASIS_W'(r_nz1) <<< 14;
        n_b[3] = BASIS_W'(r_nx1) <<< 14;
        n_b[4] = BASIS_W'(r_nxy);
        n_b[5] = BASIS_W'(r_nyz);
        n_b[6] = (BASIS_W'(r_nzz) <<< 1) - BASIS_W'(r_nxx) - BASIS_W'(r_nyy);
        n_b[7] = BASIS_W'(r_nzx);
        n_b[8] = BASIS_W'(r_nxx) - BASIS_W'(r_nyy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b2  <= n_b;
            r_d2v <= n_d[31:0];
            r_p2  <= n_p2s[31:0];
            r_ok2 <= r_nv1 && (n_d > 34'sd0) && (n_p2s != 34'sd0);
            r_cr2 <= r_cr1;
            r_cg2 <= r_cg1;
            r_cb2 <= r_cb1;
        end
    end

    // stage 3: coefficient products and squared view terms
    logic signed [TERM_W-1:0] r_term [9];
    logic [63:0]              r_dsq, r_rhs;
    logic                     r_ok3;
    logic [7:0]               r_cr3, r_cg3, r_cb3;

    for (genvar g = 0; g < 9; g++) begin : g_term
        logic signed [COEFF_WIDTH-1:0] w_coef;
        assign w_coef = $signed(i_coeffs[(g/3)*CFG_DATA_W + (g%3)*COEFF_WIDTH +: COEFF_WIDTH]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_term[g] <= TERM_W'(w_coef) * TERM_W'(r_b2[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsq <= 64'(r_d2v) * 64'(r_d2v);
            r_rhs <= 64'(i_thr_sq) * 64'(r_p2);
            r_ok3 <= r_ok2;
            r_cr3 <= r_cr2;
            r_cg3 <= r_cg2;
            r_cb3 <= r_cb2;
        end
    end

    // stage 4: partial sums and angle test
    logic signed [SUM_W-1:0] r_part [3];
    logic                    r_vis4;
    logic [7:0]              r_cr4, r_cg4, r_cb4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_part[j] <= SUM_W'(r_term[3*j]) + SUM_W'(r_term[3*j+1])
                           + SUM_W'(r_term[3*j+2]);
            end
            r_vis4 <= r_ok3 && (r_dsq > (r_rhs >> 4));
            r_cr4  <= r_cr3;
            r_cg4  <= r_cg3;
            r_cb4  <= r_cb3;
        end
    end

    // stage 5: total shading
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_front.shade       <= r_part[0] + r_part[1] + r_part[2];
            o_front.visible     <= r_vis4;
            o_front.color_red   <= r_cr4;
            o_front.color_green <= r_cg4;
            o_front.color_blue  <= r_cb4;
        end
    end

endmodule
`default_nettype wire

// ===== src/shalb_div.sv =====
`default_nettype none
module shalb_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [7:0]                          i_color,
    input  wire logic signed [shalb_pkg::SUM_W-1:0]  i_shade,
    output logic [7:0]                               o_albedo,
    output logic [7:0]                               o_irradiance
);
    import shalb_pkg::*;

    logic [SUM_W-2:0] w_su;
    logic [DIV_W-1:0] w_num, w_su8, w_tfull;
    logic [7:0]       w_t, w_irr;
    logic             w_big;

    always_comb begin
        w_su    = i_shade[SUM_W-2:0];
        w_num   = DIV_W'({i_color, {Q_SHADE{1'b0}}});
        w_su8   = DIV_W'(w_su) << 8;
        w_tfull = (w_su8 - DIV_W'(w_su)) >> Q_SHADE;
        w_big   = DIV_W'(w_su) >= (DIV_W'(1) << Q_SHADE);
        w_t     = w_big ? 8'd255 : w_tfull[7:0];
        w_irr   = (i_color < w_t) ? i_color : w_t;
    end

    logic [NUM_W-1:0] r_rem  [DIV_STEPS+1];
    logic [7:0]       r_q    [DIV_STEPS+1];
    logic [SUM_W-2:0] r_su   [DIV_STEPS+1];
    logic [7:0]       r_col  [DIV_STEPS+1];
    logic [7:0]       r_irr  [DIV_STEPS+1];
    logic             r_zero [DIV_STEPS+1];
    logic             r_neg  [DIV_STEPS+1];
    logic             r_sat  [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num[NUM_W-1:0];
            r_q[0]    <= 8'd0;
            r_su[0]   <= w_su;
            r_col[0]  <= i_color;
            r_irr[0]  <= w_irr;
            r_zero[0] <= (i_shade == '0);
            r_neg[0]  <= i_shade[SUM_W-1];
            r_sat[0]  <= w_num >= w_su8;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        logic [DIV_W-1:0] w_sub;
        logic             w_fit;
        assign w_sub = DIV_W'(r_su[k]) << SH;
        assign w_fit = DIV_W'(r_rem[k]) >= w_sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_fit ? NUM_W'(DIV_W'(r_rem[k]) - w_sub) : r_rem[k];
                r_q[k+1]    <= r_q[k] | (w_fit ? (8'd1 << SH) : 8'd0);
                r_su[k+1]   <= r_su[k];
                r_col[k+1]  <= r_col[k];
                r_irr[k+1]  <= r_irr[k];
                r_zero[k+1] <= r_zero[k];
                r_neg[k+1]  <= r_neg[k];
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    always_comb begin
        if (r_zero[DIV_STEPS]) begin
            o_albedo     = (r_col[DIV_STEPS] != 8'd0) ? 8'd255 : 8'd0;
            o_irradiance = 8'd0;
        end else if (r_neg[DIV_STEPS]) begin
            o_albedo     = 8'd0;
            o_irradiance = 8'd0;
        end else begin
            o_albedo     = r_sat[DIV_STEPS] ? 8'd255 : r_q[DIV_STEPS];
            o_irradiance = r_irr[DIV_STEPS];
        end
    end

endmodule
`default_nettype wire

// ===== src/sh_albedo_irradiance_pixel_core.sv =====
`default_nettype none
// Per-pixel spherical-harmonic shading core: takes one pixel item per cycle while the
// output is not stalled and returns albedo and irradiance per color channel through
// the front stages for the products, view test and nine-term shading sum, the setup
// register and the quotient-bit stages of the pipelined restoring divider, and the
// output register. Output stall freezes the whole pipeline; no item is lost.
// Config writes take effect through the config registers (the threshold also through
// the threshold square register) and must be made while the pipeline holds no item.
module sh_albedo_irradiance_pixel_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire shalb_pkg::t_pix_in                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output shalb_pkg::t_pix_out                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [shalb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [shalb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import shalb_pkg::*;

    localparam int LAT = FRONT_LAT + DIV_STEPS + 1;

    logic [15:0]             r_thr;
    logic [31:0]             r_thr_sq;
    logic [CFG_DATA_W-1:0]   r_coef [3];
    logic                    w_en;
    t_front_out              w_front;
    logic [7:0]              w_alb [3];
    logic [7:0]              w_irr [3];
    logic [LAT-1:0]          r_vld;
    logic [DIV_STEPS:0]      r_vis;
    logic                    r_out_valid;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESH_RESET;
            r_coef[0] <= COEFF_0_RESET;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESH:  r_thr     <= i_cfg_data[15:0];
                REG_COEFF_0: r_coef[0] <= i_cfg_data;
                REG_COEFF_1: r_coef[1] <= i_cfg_data;
                REG_COEFF_2: r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= 32'(r_thr) * 32'(r_thr);
    end

    shalb_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pix    (i_in_data),
        .i_thr_sq (r_thr_sq),
        .i_coeffs ({r_coef[2], r_coef[1], r_coef[0]}),
        .o_front  (w_front)
    );

    shalb_div u_div_r (
        .i_clk(i_clk), .i_en(w_en), .i_color(w_front.color_red), .i_shade(w_front.shade),
        .o_albedo(w_alb[0]), .o_irradiance(w_irr[0])
    );
    shalb_div u_div_g (
        .i_clk(i_clk), .i_en(w_en), .i_color(w_front.color_green), .i_shade(w_front.shade),
        .o_albedo(w_alb[1]), .o_irradiance(w_irr[1])
    );
    shalb_div u_div_b (
        .i_clk(i_clk), .i_en(w_en), .i_color(w_front.color_blue), .i_shade(w_front.shade),
        .o_albedo(w_alb[2]), .o_irradiance(w_irr[2])
    );

    // valid bits travel alongside the data; the output register is the last stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vis <= {r_vis[DIV_STEPS-1:0], w_front.visible};
            if (r_vis[DIV_STEPS]) begin
                o_out_data.visible          <= 1'b1;
                o_out_data.albedo_red       <= w_alb[0];
                o_out_data.albedo_green     <= w_alb[1];
                o_out_data.albedo_blue      <= w_alb[2];
                o_out_data.irradiance_red   <= w_irr[0];
                o_out_data.irradiance_green <= w_irr[1];
                o_out_data.irradiance_blue  <= w_irr[2];
            end else begin
                o_out_data <= '0;
            end
        end
    end

endmodule
`default_nettype wire
